/* design/assert_macros.svh */
// Assertion macros for the restart condition monitor.
// Used by the top level; compiled to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* design/rcm_pkg.sv */
// Package for the restart condition monitor: payload, configuration and
// control types, register indexes and reset values. No dependencies.
`default_nettype none
package rcm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int MAX_PERIOD_DEF = 64;

    localparam int W_FIT      = 32;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;

    localparam logic [W_CFG_IDX-1:0] CFG_MAX_ITER  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_WIN_LEN   = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_TOLERANCE = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_SIGMA_MIN = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_SIGMA_MAX = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_FLAT_PER  = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_FLAT_LIM  = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_FLAT_EN   = 3'd7;

    localparam logic [31:0] RST_MAX_ITER  = 32'd1000;
    localparam logic [6:0]  RST_WIN_LEN   = 7'd16;
    localparam logic [30:0] RST_TOLERANCE = 31'd0;
    localparam logic [31:0] RST_SIGMA_MIN = 32'd0;
    localparam logic [31:0] RST_SIGMA_MAX = 32'hFFFF_FFFF;
    localparam logic [6:0]  RST_FLAT_PER  = 7'd10;
    localparam logic [6:0]  RST_FLAT_LIM  = 7'd4;
    localparam logic        RST_FLAT_EN   = 1'b1;

    localparam logic OP_GENERATION = 1'b0;
    localparam logic OP_RESTART    = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [W_FIT-1:0] best_fitness;
        logic signed [W_FIT-1:0] compare_fitness;
        logic [W_FIT-1:0]        step_size;
        logic                    adapt_ok;
        logic                    step_finite;
    } t_rcm_in;

    typedef struct packed {
        logic iter_exceeded;
        logic no_improvement;
        logic sigma_too_small;
        logic sigma_too_large;
        logic unable_to_adapt;
        logic flat_fitness;
        logic any_restart;
    } t_rcm_out;

    typedef struct packed {
        logic [31:0] max_iterations;
        logic [6:0]  window_length;
        logic [30:0] improvement_tolerance;
        logic [31:0] sigma_min;
        logic [31:0] sigma_max;
        logic [6:0]  flat_period;
        logic [6:0]  flat_limit;
        logic        flat_enable;
    } t_rcm_cfg;

    typedef struct packed {
        logic gen;
        logic clr;
        logic scan;
        logic load;
    } t_rcm_cmd;

    typedef struct packed {
        logic scan_last;
    } t_rcm_sts;

endpackage
`default_nettype wire

/* design/rcm_ctrl.sv */
// Controller state machine of the restart condition monitor.
// Depends on rcm_pkg; drives commands to rcm_dpath.
`default_nettype none
module rcm_ctrl
    import rcm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_opcode,
    input  wire logic     i_out_free,
    input  wire t_rcm_sts i_sts,
    output t_rcm_cmd      o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd.gen  = w_accept && (i_opcode == OP_GENERATION);
        o_cmd.clr  = w_accept && (i_opcode == OP_RESTART);
        o_cmd.scan = (r_state == S_SCAN);
        o_cmd.load = (r_state == S_FINISH) && i_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_opcode == OP_RESTART) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* design/rcm_dpath.sv */
// Datapath of the restart condition monitor: history counters, fitness
// window memory, flat flag ring, range and flat-count scan. Uses rcm_pkg.
`default_nettype none
module rcm_dpath
    import rcm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rcm_cfg i_cfg,
    input  wire t_rcm_in  i_in,
    input  wire t_rcm_cmd i_cmd,
    output t_rcm_sts      o_sts,
    output t_rcm_out      o_result
);

    localparam int MAX_SCAN = (MAX_WINDOW > MAX_PERIOD) ? MAX_WINDOW : MAX_PERIOD;
    localparam int W_CNT    = $clog2(MAX_SCAN + 1);
    localparam int W_CMP    = (W_CNT > 7) ? W_CNT : 7;
    localparam int W_WA     = $clog2(MAX_WINDOW);
    localparam int W_FILL   = $clog2(MAX_WINDOW + 1);
    localparam int W_PH     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

    localparam logic [W_CMP-1:0]  WIN_CAP  = W_CMP'(MAX_WINDOW);
    localparam logic [W_CMP-1:0]  PER_CAP  = W_CMP'(MAX_PERIOD);
    localparam logic [W_FILL-1:0] FILL_CAP = W_FILL'(MAX_WINDOW);
    localparam logic [W_WA-1:0]   HEAD_TOP = W_WA'(MAX_WINDOW - 1);

    logic signed [W_FIT-1:0] r_mem [MAX_WINDOW];

    logic [31:0]             r_gens;
    logic [W_WA-1:0]         r_head;
    logic [W_FILL-1:0]       r_fill;
    logic [MAX_PERIOD-1:0]   r_flags;
    logic [W_PH-1:0]         r_phase;

    logic                    r_restart_item;
    logic                    r_f_iter;
    logic                    r_f_small;
    logic                    r_f_large;
    logic                    r_f_adapt;
    logic                    r_noimp_chk;
    logic                    r_flat_chk;
    logic [W_CMP-1:0]        r_na;
    logic [W_CMP-1:0]        r_per;
    logic [W_CMP-1:0]        r_len;
    logic [W_CMP-1:0]        r_idx;
    logic [W_CMP-1:0]        r_sum;
    logic [W_WA-1:0]         r_rd_addr;
    logic signed [W_FIT-1:0] r_rd_data;
    logic                    r_rd_vld;
    logic                    r_rd_first;
    logic signed [W_FIT-1:0] r_lo;
    logic signed [W_FIT-1:0] r_hi;

    logic [31:0]       w_gens_inc;
    logic [W_CMP-1:0]  w_wl_raw;
    logic [W_CMP-1:0]  w_wl;
    logic [W_FILL-1:0] w_fill_new;
    logic [W_CMP-1:0]  w_fill_ext;
    logic [W_CMP-1:0]  w_na;
    logic [W_CMP-1:0]  w_per_raw;
    logic [W_CMP-1:0]  w_per;
    logic [W_PH-1:0]   w_phase_eff;
    logic [W_PH-1:0]   w_phase_nxt;
    logic [W_CMP-1:0]  w_len;
    logic signed [W_FIT:0] w_range;
    logic              w_noimp;
    logic              w_flat;

    always_comb begin
        w_gens_inc = (r_gens == 32'hFFFF_FFFF) ? r_gens : r_gens + 32'd1;
        w_wl_raw   = W_CMP'(i_cfg.window_length);
        w_wl       = (w_wl_raw > WIN_CAP) ? WIN_CAP : w_wl_raw;
        w_fill_new = (r_fill == FILL_CAP) ? r_fill : r_fill + W_FILL'(1);
        w_fill_ext = W_CMP'(w_fill_new);
        w_na       = (w_fill_ext < w_wl) ? w_fill_ext : w_wl;
        w_per_raw  = W_CMP'(i_cfg.flat_period);
        if (w_per_raw == '0) begin
            w_per = W_CMP'(1);
        end else if (w_per_raw > PER_CAP) begin
            w_per = PER_CAP;
        end else begin
            w_per = w_per_raw;
        end
        w_phase_eff = (W_CMP'(r_phase) >= w_per) ? '0 : r_phase;
        w_phase_nxt = ((W_CMP'(w_phase_eff) + W_CMP'(1)) == w_per) ? '0
                    : w_phase_eff + W_PH'(1);
        if (i_cfg.flat_enable && (w_per > w_na)) begin
            w_len = w_per;
        end else begin
            w_len = w_na;
        end
    end

    assign o_sts.scan_last = ((r_idx + W_CMP'(1)) >= r_len);

    // window store: written on a generation, read once per scan cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen) begin
            r_mem[r_head] <= i_in.best_fitness;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gens         <= '0;
            r_head         <= '0;
            r_fill         <= '0;
            r_flags        <= '0;
            r_phase        <= '0;
            r_restart_item <= 1'b0;
            r_rd_vld       <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_gens         <= '0;
                r_head         <= '0;
                r_fill         <= '0;
                r_flags        <= '0;
                r_restart_item <= 1'b1;
            end else if (i_cmd.gen) begin
                r_gens         <= w_gens_inc;
                r_head         <= (r_head == HEAD_TOP) ? '0 : r_head + W_WA'(1);
                r_fill         <= w_fill_new;
                r_restart_item <= 1'b0;
                if (i_cfg.flat_enable) begin
                    r_flags[w_phase_eff] <= (i_in.best_fitness == i_in.compare_fitness);
                    r_phase              <= w_phase_nxt;
                end
            end
            r_rd_vld <= i_cmd.scan && (r_idx < r_na);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen) begin
            r_f_iter    <= i_cfg.max_iterations < w_gens_inc;
            r_f_small   <= i_in.step_size < i_cfg.sigma_min;
            r_f_large   <= i_in.step_size > i_cfg.sigma_max;
            r_f_adapt   <= !i_in.adapt_ok || !i_in.step_finite;
            r_noimp_chk <= w_gens_inc > 32'(w_wl);
            r_flat_chk  <= i_cfg.flat_enable && (w_gens_inc > 32'(w_per));
            r_na        <= w_na;
            r_per       <= i_cfg.flat_enable ? w_per : '0;
            r_len       <= w_len;
            r_idx       <= '0;
            r_sum       <= '0;
            r_rd_addr   <= r_head;
        end else if (i_cmd.scan) begin
            r_idx      <= r_idx + W_CMP'(1);
            r_rd_addr  <= (r_rd_addr == '0) ? HEAD_TOP : r_rd_addr - W_WA'(1);
            r_rd_first <= (r_idx == '0);
            if (r_idx < r_per) begin
                r_sum <= r_sum + W_CMP'(r_flags[r_idx[W_PH-1:0]]);
            end
        end
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_lo <= r_rd_data;
                r_hi <= r_rd_data;
            end else begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end
    end

    always_comb begin
        w_range = (W_FIT + 1)'(r_hi) - (W_FIT + 1)'(r_lo);
        w_noimp = r_noimp_chk && ((r_na <= W_CMP'(1)) ||
                  (unsigned'(w_range) <= (W_FIT + 1)'(i_cfg.improvement_tolerance)));
        w_flat  = r_flat_chk && (r_sum > W_CMP'(i_cfg.flat_limit));
        if (r_restart_item) begin
            o_result = '0;
        end else begin
            o_result.iter_exceeded   = r_f_iter;
            o_result.no_improvement  = w_noimp;
            o_result.sigma_too_small = r_f_small;
            o_result.sigma_too_large = r_f_large;
            o_result.unable_to_adapt = r_f_adapt;
            o_result.flat_fitness    = w_flat;
            o_result.any_restart     = r_f_iter || w_noimp || r_f_small ||
                                       r_f_large || r_f_adapt || w_flat;
        end
    end

endmodule
`default_nettype wire

/* design/restart_condition_monitor_top.sv */
// A generation result is registered after a single-port scan of L slots, where
// L = max(1, min(window fill, window_length), flat_period when flat_enable), both
// lengths saturated; a restart result is registered without a scan. An item holds
// o_in_stall high until its result is loaded, which waits on an output stall.
// Reset is synchronous, active low: clears history, loads register defaults.
// The window store needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module restart_condition_monitor_top
    import rcm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_rcm_in               i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_rcm_out                   o_out_data
);

    t_rcm_cfg r_cfg;
    t_rcm_cmd w_cmd;
    t_rcm_sts w_sts;
    t_rcm_out w_result;
    logic     w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iterations        <= RST_MAX_ITER;
            r_cfg.window_length         <= RST_WIN_LEN;
            r_cfg.improvement_tolerance <= RST_TOLERANCE;
            r_cfg.sigma_min             <= RST_SIGMA_MIN;
            r_cfg.sigma_max             <= RST_SIGMA_MAX;
            r_cfg.flat_period           <= RST_FLAT_PER;
            r_cfg.flat_limit            <= RST_FLAT_LIM;
            r_cfg.flat_enable           <= RST_FLAT_EN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ITER:  r_cfg.max_iterations        <= i_cfg_data;
                CFG_WIN_LEN:   r_cfg.window_length         <= i_cfg_data[6:0];
                CFG_TOLERANCE: r_cfg.improvement_tolerance <= i_cfg_data[30:0];
                CFG_SIGMA_MIN: r_cfg.sigma_min             <= i_cfg_data;
                CFG_SIGMA_MAX: r_cfg.sigma_max             <= i_cfg_data;
                CFG_FLAT_PER:  r_cfg.flat_period           <= i_cfg_data[6:0];
                CFG_FLAT_LIM:  r_cfg.flat_limit            <= i_cfg_data[6:0];
                CFG_FLAT_EN:   r_cfg.flat_enable           <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !o_out_valid || !i_out_stall;

    rcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_in_stall)
    );

    rcm_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in_data),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.load) begin
            o_out_data <= w_result;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPLIES(a_any_is_or, i_clk, i_rst_n, o_out_valid, o_out_data.any_restart == (o_out_data.iter_exceeded || o_out_data.no_improvement || o_out_data.sigma_too_small || o_out_data.sigma_too_large || o_out_data.unable_to_adapt || o_out_data.flat_fitness))
    `ASSERT_IMPLIES(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule
`default_nettype wire
